>>> rtl/wav_header_parser_core_macros.svh
// assertion macros for the wav header parser
`ifndef WAV_HEADER_PARSER_CORE_MACROS_SVH
`define WAV_HEADER_PARSER_CORE_MACROS_SVH

// property checked on every rising edge of clk_i outside reset
`define WAVHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression that must never hold
`define WAVHP_ASSERT_NEVER(lbl, expr, msg) \
  `WAVHP_ASSERT(lbl, !(expr), msg)

`endif

>>> rtl/wavhp_pkg.sv
// types and constants shared by the wav header parser modules
package wavhp_pkg;

  localparam int unsigned PosW = 4;

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  localparam logic [31:0] FmtMin = 32'd16;

  localparam logic [PosW-1:0] PosTagLast    = 4'd3;
  localparam logic [PosW-1:0] PosFieldsLast = 4'd15;

  typedef enum logic [3:0] {
    PhIdle,
    PhRiff,
    PhRsize,
    PhWave,
    PhFmtTag,
    PhFmtSize,
    PhFields,
    PhSkip,
    PhDataTag,
    PhDataSize,
    PhData
  } phase_e;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindSample = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrRiff     = 3'd1,
    ErrWave     = 3'd2,
    ErrFmtTag   = 3'd3,
    ErrDataTag  = 3'd4,
    ErrFmtShort = 3'd5
  } err_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] audio_format;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
    logic [7:0]  sample_byte;
    logic        frame_end;
    logic        last_data;
    err_e        error_code;
  } res_t;

endpackage

>>> rtl/wavhp_if.sv
// input and result channel interfaces of the wav header parser
interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       start_of_file;

  modport source (output valid, output byte_value, output start_of_file, input ready);
  modport sink (input valid, input byte_value, input start_of_file, output ready);
endinterface

interface wavhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] audio_format;
  logic [15:0] num_channels;
  logic [31:0] sample_rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [15:0] bits_per_sample;
  logic [31:0] data_size;
  logic [7:0]  sample_byte;
  logic        frame_end;
  logic        last_data;
  logic [2:0]  error_code;

  modport source (
    output valid, output kind, output audio_format, output num_channels,
    output sample_rate, output byte_rate, output block_align,
    output bits_per_sample, output data_size, output sample_byte,
    output frame_end, output last_data, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input audio_format, input num_channels,
    input sample_rate, input byte_rate, input block_align,
    input bits_per_sample, input data_size, input sample_byte,
    input frame_end, input last_data, input error_code, output ready
  );
endinterface

>>> rtl/wavhp_in_stage.sv
// input register stage of the wav header parser
module wavhp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  wavhp_in_if.sink          in_i,
  input  logic              advance_i,
  output wavhp_pkg::item_t  item_o,
  output logic              valid_o
);

  wavhp_pkg::item_t item_q;
  logic             valid_q;
  logic             ready;

  assign ready    = !valid_q || advance_i;
  assign in_i.ready = ready;
  assign item_o   = item_q;
  assign valid_o  = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_i.valid) begin
      item_q.byte_value    <= in_i.byte_value;
      item_q.start_of_file <= in_i.start_of_file;
    end
  end

endmodule

>>> rtl/wavhp_parse.sv
// parse state and per-byte decode of the wav header parser
module wavhp_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  wavhp_pkg::item_t item_i,
  output logic             res_valid_o,
  output wavhp_pkg::res_t  res_o
);

  wavhp_pkg::phase_e                phase_q, phase_d;
  logic [wavhp_pkg::PosW-1:0]       pos_q, pos_d;
  logic [31:0]                      tag_q, tag_d;
  logic [31:0]                      fmt_len_q, fmt_len_d;
  logic [15:0]                      format_q, format_d;
  logic [15:0]                      chans_q, chans_d;
  logic [31:0]                      srate_q, srate_d;
  logic [31:0]                      brate_q, brate_d;
  logic [15:0]                      align_q, align_d;
  logic [15:0]                      bits_q, bits_d;
  logic [31:0]                      remain_q, remain_d;
  logic [15:0]                      fcnt_q, fcnt_d;

  always_comb begin
    wavhp_pkg::phase_e          ph;
    logic [wavhp_pkg::PosW-1:0] pos;
    logic [31:0]                tag;
    logic [31:0]                shifted;
    logic [31:0]                le;
    logic [31:0]                want;
    wavhp_pkg::phase_e          ok_phase;
    wavhp_pkg::err_e            code;
    logic [15:0]                cnt;

    ph      = item_i.start_of_file ? wavhp_pkg::PhRiff : phase_q;
    pos     = item_i.start_of_file ? '0 : pos_q;
    tag     = item_i.start_of_file ? '0 : tag_q;
    shifted = {tag[23:0], item_i.byte_value};
    le      = {item_i.byte_value, tag[31:8]};
    cnt     = fcnt_q + 16'd1;

    phase_d   = ph;
    pos_d     = pos;
    tag_d     = tag;
    fmt_len_d = fmt_len_q;
    format_d  = format_q;
    chans_d   = chans_q;
    srate_d   = srate_q;
    brate_d   = brate_q;
    align_d   = align_q;
    bits_d    = bits_q;
    remain_d  = remain_q;
    fcnt_d    = fcnt_q;

    res_valid_o = 1'b0;
    res_o       = '0;

    case (ph)
      wavhp_pkg::PhRiff: begin
        want = wavhp_pkg::TagRiff; ok_phase = wavhp_pkg::PhRsize; code = wavhp_pkg::ErrRiff;
      end
      wavhp_pkg::PhWave: begin
        want = wavhp_pkg::TagWave; ok_phase = wavhp_pkg::PhFmtTag; code = wavhp_pkg::ErrWave;
      end
      wavhp_pkg::PhFmtTag: begin
        want = wavhp_pkg::TagFmt; ok_phase = wavhp_pkg::PhFmtSize; code = wavhp_pkg::ErrFmtTag;
      end
      default: begin
        want = wavhp_pkg::TagData; ok_phase = wavhp_pkg::PhDataSize;
        code = wavhp_pkg::ErrDataTag;
      end
    endcase

    case (ph)
      wavhp_pkg::PhRiff, wavhp_pkg::PhWave, wavhp_pkg::PhFmtTag,
      wavhp_pkg::PhDataTag: begin
        tag_d = shifted;
        pos_d = pos + 4'd1;
        if (pos == wavhp_pkg::PosTagLast) begin
          pos_d = '0;
          tag_d = '0;
          if (shifted != want) begin
            res_valid_o      = 1'b1;
            res_o.kind       = wavhp_pkg::KindError;
            res_o.error_code = code;
            phase_d          = wavhp_pkg::PhIdle;
          end else begin
            phase_d = ok_phase;
          end
        end
      end
      wavhp_pkg::PhRsize: begin
        pos_d = pos + 4'd1;
        if (pos == wavhp_pkg::PosTagLast) begin
          pos_d   = '0;
          tag_d   = '0;
          phase_d = wavhp_pkg::PhWave;
        end
      end
      wavhp_pkg::PhFmtSize: begin
        tag_d = le;
        pos_d = pos + 4'd1;
        if (pos == wavhp_pkg::PosTagLast) begin
          pos_d = '0;
          tag_d = '0;
          if (le < wavhp_pkg::FmtMin) begin
            res_valid_o      = 1'b1;
            res_o.kind       = wavhp_pkg::KindError;
            res_o.error_code = wavhp_pkg::ErrFmtShort;
            phase_d          = wavhp_pkg::PhIdle;
          end else begin
            fmt_len_d = le - wavhp_pkg::FmtMin;
            phase_d   = wavhp_pkg::PhFields;
          end
        end
      end
      wavhp_pkg::PhFields: begin
        tag_d = le;
        pos_d = pos + 4'd1;
        case (pos)
          4'd1:    format_d = le[31:16];
          4'd3:    chans_d  = le[31:16];
          4'd7:    srate_d  = le;
          4'd11:   brate_d  = le;
          4'd13:   align_d  = le[31:16];
          4'd15:   bits_d   = le[31:16];
          default: ;
        endcase
        if (pos == wavhp_pkg::PosFieldsLast) begin
          pos_d   = '0;
          tag_d   = '0;
          phase_d = (fmt_len_q != '0) ? wavhp_pkg::PhSkip : wavhp_pkg::PhDataTag;
        end
      end
      wavhp_pkg::PhSkip: begin
        fmt_len_d = fmt_len_q - 32'd1;
        if (fmt_len_q == 32'd1) begin
          pos_d   = '0;
          tag_d   = '0;
          phase_d = wavhp_pkg::PhDataTag;
        end
      end
      wavhp_pkg::PhDataSize: begin
        tag_d = le;
        pos_d = pos + 4'd1;
        if (pos == wavhp_pkg::PosTagLast) begin
          pos_d                 = '0;
          tag_d                 = '0;
          remain_d              = le;
          fcnt_d                = '0;
          res_valid_o           = 1'b1;
          res_o.kind            = wavhp_pkg::KindHeader;
          res_o.audio_format    = format_q;
          res_o.num_channels    = chans_q;
          res_o.sample_rate     = srate_q;
          res_o.byte_rate       = brate_q;
          res_o.block_align     = align_q;
          res_o.bits_per_sample = bits_q;
          res_o.data_size       = le;
          res_o.last_data       = (le == '0);
          phase_d               = (le == '0) ? wavhp_pkg::PhIdle : wavhp_pkg::PhData;
        end
      end
      wavhp_pkg::PhData: begin
        res_valid_o       = 1'b1;
        res_o.kind        = wavhp_pkg::KindSample;
        res_o.sample_byte = item_i.byte_value;
        fcnt_d            = cnt;
        if (align_q != '0 && cnt == align_q) begin
          res_o.frame_end = 1'b1;
          fcnt_d          = '0;
        end
        remain_d = remain_q - 32'd1;
        if (remain_q == 32'd1) begin
          res_o.last_data = 1'b1;
          pos_d           = '0;
          tag_d           = '0;
          phase_d         = wavhp_pkg::PhIdle;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wavhp_pkg::PhIdle;
      pos_q     <= '0;
      tag_q     <= '0;
      fmt_len_q <= '0;
      format_q  <= '0;
      chans_q   <= '0;
      srate_q   <= '0;
      brate_q   <= '0;
      align_q   <= '0;
      bits_q    <= '0;
      remain_q  <= '0;
      fcnt_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      tag_q     <= tag_d;
      fmt_len_q <= fmt_len_d;
      format_q  <= format_d;
      chans_q   <= chans_d;
      srate_q   <= srate_d;
      brate_q   <= brate_d;
      align_q   <= align_d;
      bits_q    <= bits_d;
      remain_q  <= remain_d;
      fcnt_q    <= fcnt_d;
    end
  end

endmodule

>>> rtl/wav_header_parser_core.sv
// top level of the wav header parser: input stage, parser and result register
//
//   channel  dir  payload                                   handshake
//   in_i     in   byte_value, start_of_file                 valid/ready
//   out_o    out  kind, fmt fields, data_size, sample_byte,  valid/ready
//                 frame_end, last_data, error_code
//
// one byte per cycle sustained while the result channel is not stalled; a result is
// registered into the result register through the input register and one decode step
// the parse state updates once per item in the decode step, which sets the rate
// reset clears the parse state to idle and empties both registers
// a stalled result holds the decode step; bytes with no result still wait for it
`include "wav_header_parser_core_macros.svh"

module wav_header_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  wavhp_in_if.sink    in_i,
  wavhp_out_if.source out_o
);

  wavhp_pkg::item_t item;
  logic             item_valid;
  logic             advance;
  logic             res_valid;
  wavhp_pkg::res_t  res;
  wavhp_pkg::res_t  out_q;
  logic             out_valid_q;
  logic             out_err_no_code;
  logic             out_end_other;

  assign advance = item_valid && (!out_valid_q || out_o.ready);

  wavhp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .item_o    (item),
    .valid_o   (item_valid)
  );

  wavhp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.kind            = out_q.kind;
  assign out_o.audio_format    = out_q.audio_format;
  assign out_o.num_channels    = out_q.num_channels;
  assign out_o.sample_rate     = out_q.sample_rate;
  assign out_o.byte_rate       = out_q.byte_rate;
  assign out_o.block_align     = out_q.block_align;
  assign out_o.bits_per_sample = out_q.bits_per_sample;
  assign out_o.data_size       = out_q.data_size;
  assign out_o.sample_byte     = out_q.sample_byte;
  assign out_o.frame_end       = out_q.frame_end;
  assign out_o.last_data       = out_q.last_data;
  assign out_o.error_code      = out_q.error_code;

  assign out_err_no_code = out_valid_q && (out_q.kind == wavhp_pkg::KindError) &&
                           (out_q.error_code == wavhp_pkg::ErrNone);
  assign out_end_other   = out_valid_q && out_q.frame_end &&
                           (out_q.kind != wavhp_pkg::KindSample);

  `WAVHP_ASSERT(a_ready_when_empty, !out_valid_q |-> in_i.ready, "input stalled while empty")
  `WAVHP_ASSERT_NEVER(a_error_has_code, out_err_no_code, "error item without a code")
  `WAVHP_ASSERT_NEVER(a_frame_end_sample, out_end_other, "frame end on a non-sample item")

endmodule

>>> bench/wav_header_parser_core_tb.sv
// testbench for wav_header_parser_core: byte stream stimulus, parse predictor and result check
module wav_header_parser_core_tb;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomBytes = 600;

  class wav_parse_tracker;
    wavhp_pkg::phase_e phase;
    logic [31:0]       pos;
    logic [31:0]       shift;
    logic [31:0]       fmt_left;
    logic [15:0]       fmt_code;
    logic [15:0]       chans;
    logic [31:0]       srate;
    logic [31:0]       brate;
    logic [15:0]       align;
    logic [15:0]       sample_bits;
    logic [31:0]       data_left;
    logic [15:0]       frame_cnt;
    wavhp_pkg::res_t   expected_q[$];
    int unsigned       mismatches;
    int unsigned       live_bytes;

    function new();
      clear();
      mismatches = 0;
      live_bytes = 0;
    endfunction

    function void clear();
      phase       = wavhp_pkg::PhIdle;
      pos         = '0;
      shift       = '0;
      fmt_left    = '0;
      fmt_code    = '0;
      chans       = '0;
      srate       = '0;
      brate       = '0;
      align       = '0;
      sample_bits = '0;
      data_left   = '0;
      frame_cnt   = '0;
    endfunction

    function void advance(wavhp_pkg::phase_e nxt);
      phase = nxt;
      pos   = '0;
      shift = '0;
    endfunction

    function bit raise(wavhp_pkg::err_e code, inout wavhp_pkg::res_t r);
      r.kind       = wavhp_pkg::KindError;
      r.error_code = code;
      advance(wavhp_pkg::PhIdle);
      return 1'b1;
    endfunction

    function bit parse_byte(input logic [7:0] b, input logic sof,
                            output wavhp_pkg::res_t r);
      logic [31:0]       le;
      logic [31:0]       want;
      wavhp_pkg::err_e   code;
      wavhp_pkg::phase_e nxt;
      r = '0;
      if (sof) begin
        clear();
        phase = wavhp_pkg::PhRiff;
      end
      le = {b, shift[31:8]};
      case (phase)
        wavhp_pkg::PhRiff, wavhp_pkg::PhWave, wavhp_pkg::PhFmtTag,
        wavhp_pkg::PhDataTag: begin
          shift = {shift[23:0], b};
          pos++;
          if (pos < 4) return 1'b0;
          case (phase)
            wavhp_pkg::PhRiff: begin
              want = wavhp_pkg::TagRiff; code = wavhp_pkg::ErrRiff;
              nxt = wavhp_pkg::PhRsize;
            end
            wavhp_pkg::PhWave: begin
              want = wavhp_pkg::TagWave; code = wavhp_pkg::ErrWave;
              nxt = wavhp_pkg::PhFmtTag;
            end
            wavhp_pkg::PhFmtTag: begin
              want = wavhp_pkg::TagFmt; code = wavhp_pkg::ErrFmtTag;
              nxt = wavhp_pkg::PhFmtSize;
            end
            default: begin
              want = wavhp_pkg::TagData; code = wavhp_pkg::ErrDataTag;
              nxt = wavhp_pkg::PhDataSize;
            end
          endcase
          if (shift != want) return raise(code, r);
          advance(nxt);
          return 1'b0;
        end
        wavhp_pkg::PhRsize: begin
          pos++;
          if (pos >= 4) advance(wavhp_pkg::PhWave);
          return 1'b0;
        end
        wavhp_pkg::PhFmtSize: begin
          shift = le;
          pos++;
          if (pos < 4) return 1'b0;
          if (shift < wavhp_pkg::FmtMin) return raise(wavhp_pkg::ErrFmtShort, r);
          fmt_left = shift - wavhp_pkg::FmtMin;
          advance(wavhp_pkg::PhFields);
          return 1'b0;
        end
        wavhp_pkg::PhFields: begin
          shift = le;
          case (pos)
            1:  fmt_code    = le[31:16];
            3:  chans       = le[31:16];
            7:  srate       = le;
            11: brate       = le;
            13: align       = le[31:16];
            15: sample_bits = le[31:16];
            default: ;
          endcase
          pos++;
          if (pos >= 16) advance(fmt_left != 0 ? wavhp_pkg::PhSkip : wavhp_pkg::PhDataTag);
          return 1'b0;
        end
        wavhp_pkg::PhSkip: begin
          fmt_left--;
          if (fmt_left == 0) advance(wavhp_pkg::PhDataTag);
          return 1'b0;
        end
        wavhp_pkg::PhDataSize: begin
          shift = le;
          pos++;
          if (pos < 4) return 1'b0;
          data_left         = shift;
          r.kind            = wavhp_pkg::KindHeader;
          r.audio_format    = fmt_code;
          r.num_channels    = chans;
          r.sample_rate     = srate;
          r.byte_rate       = brate;
          r.block_align     = align;
          r.bits_per_sample = sample_bits;
          r.data_size       = data_left;
          r.last_data       = (data_left == 0);
          frame_cnt         = '0;
          advance(data_left == 0 ? wavhp_pkg::PhIdle : wavhp_pkg::PhData);
          return 1'b1;
        end
        wavhp_pkg::PhData: begin
          r.kind        = wavhp_pkg::KindSample;
          r.sample_byte = b;
          frame_cnt++;
          if (align != 0 && frame_cnt == align) begin
            r.frame_end = 1'b1;
            frame_cnt   = '0;
          end
          data_left--;
          if (data_left == 0) begin
            r.last_data = 1'b1;
            advance(wavhp_pkg::PhIdle);
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic sof);
      wavhp_pkg::res_t r;
      if (sof || phase != wavhp_pkg::PhIdle) live_bytes++;
      if (parse_byte(b, sof, r)) expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(wavhp_pkg::res_t got);
      wavhp_pkg::res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0h", $time, got.kind);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("audio_format", 32'(want.audio_format), 32'(got.audio_format));
      check_field("num_channels", 32'(want.num_channels), 32'(got.num_channels));
      check_field("sample_rate", want.sample_rate, got.sample_rate);
      check_field("byte_rate", want.byte_rate, got.byte_rate);
      check_field("block_align", 32'(want.block_align), 32'(got.block_align));
      check_field("bits_per_sample", 32'(want.bits_per_sample), 32'(got.bits_per_sample));
      check_field("data_size", want.data_size, got.data_size);
      check_field("sample_byte", 32'(want.sample_byte), 32'(got.sample_byte));
      check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
      check_field("last_data", 32'(want.last_data), 32'(got.last_data));
      check_field("error_code", 32'(want.error_code), 32'(got.error_code));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  wavhp_in_if  in_if();
  wavhp_out_if out_if();

  wav_header_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  wav_parse_tracker tracker = new();
  int unsigned      send_idle_pct = 10;
  int unsigned      recv_idle_pct = 47;
  int unsigned      idle_cycles = 0;
  logic [7:0]       file_bytes[$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    wavhp_pkg::res_t got;
    got = '0;
    if (in_if.valid && in_if.ready) tracker.take_byte(in_if.byte_value, in_if.start_of_file);
    if (out_if.valid && out_if.ready) begin
      got.kind            = wavhp_pkg::kind_e'(out_if.kind);
      got.audio_format    = out_if.audio_format;
      got.num_channels    = out_if.num_channels;
      got.sample_rate     = out_if.sample_rate;
      got.byte_rate       = out_if.byte_rate;
      got.block_align     = out_if.block_align;
      got.bits_per_sample = out_if.bits_per_sample;
      got.data_size       = out_if.data_size;
      got.sample_byte     = out_if.sample_byte;
      got.frame_end       = out_if.frame_end;
      got.last_data       = out_if.last_data;
      got.error_code      = wavhp_pkg::err_e'(out_if.error_code);
      tracker.match_result(got);
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sof);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.byte_value    <= b;
    in_if.start_of_file <= sof;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.expected_q.size() != 0);
  endtask

  function automatic void append_byte(logic [7:0] v);
    file_bytes.insert(file_bytes.size(), v);
  endfunction

  function automatic void push_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) append_byte(v[8*i +: 8]);
  endfunction

  function automatic void push_tag(logic [31:0] t);
    for (int i = 3; i >= 0; i--) append_byte(t[8*i +: 8]);
  endfunction

  function automatic logic [15:0] pick16();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick32();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return 32'h0;
    if (sel == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic void build_file(logic [31:0] fsize, int n_skip, logic [15:0] fcode,
                                     logic [15:0] chans, logic [31:0] srate,
                                     logic [31:0] brate, logic [15:0] align,
                                     logic [15:0] sbits, logic [31:0] dsize, int n_data);
    file_bytes.delete();
    push_tag(wavhp_pkg::TagRiff);
    push_le($urandom, 4);
    push_tag(wavhp_pkg::TagWave);
    push_tag(wavhp_pkg::TagFmt);
    push_le(fsize, 4);
    push_le(32'(fcode), 2);
    push_le(32'(chans), 2);
    push_le(srate, 4);
    push_le(brate, 4);
    push_le(32'(align), 2);
    push_le(32'(sbits), 2);
    repeat (n_skip) append_byte(8'($urandom));
    push_tag(wavhp_pkg::TagData);
    push_le(dsize, 4);
    repeat (n_data) append_byte(8'($urandom));
  endfunction

  task automatic send_queued(int count);
    for (int i = 0; i < count; i++) send_byte(file_bytes[i], i == 0);
  endtask

  task automatic send_random_file();
    int          r;
    int          sel;
    int          n_skip;
    int          n_data;
    int          cut;
    int          off;
    bit          long_fmt;
    bit          long_data;
    logic [31:0] fsize;
    logic [31:0] dsize;
    logic [15:0] align;
    r = $urandom_range(0, 99);
    if (r >= 90) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      return;
    end
    fsize     = 32'd16;
    n_skip    = 0;
    long_fmt  = 1'b0;
    long_data = 1'b0;
    sel = $urandom_range(0, 9);
    if (r >= 86) begin
      fsize = $urandom_range(0, 15);
    end else if (sel < 3) begin
      n_skip = $urandom_range(1, 6);
      fsize  = 16 + n_skip;
    end else if (sel == 3 && r < 70) begin
      fsize = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
      if (fsize < 32'd100) fsize = fsize + 32'd100;
      n_skip   = $urandom_range(0, 8);
      long_fmt = 1'b1;
    end
    sel = $urandom_range(0, 19);
    if (sel < 2) begin
      dsize  = 32'd0;
      n_data = 0;
    end else if (sel < 17) begin
      dsize  = $urandom_range(1, 24);
      n_data = int'(dsize);
    end else begin
      dsize     = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
      n_data    = $urandom_range(0, 20);
      long_data = 1'b1;
    end
    sel = $urandom_range(0, 19);
    if (sel < 3) align = 16'd0;
    else if (sel < 14) align = 16'($urandom_range(1, 4));
    else if (sel < 17) align = 16'($urandom_range(5, 16));
    else align = 16'($urandom);
    build_file(fsize, n_skip, pick16(), pick16(), pick32(), pick32(), align, pick16(),
               dsize, n_data);
    if (!long_data && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
    end
    if (r >= 70 && r < 86) begin
      case ((r - 70) / 4)
        0:       off = 0;
        1:       off = 8;
        2:       off = 12;
        default: off = 36 + n_skip;
      endcase
      off = off + $urandom_range(0, 3);
      file_bytes[off] = file_bytes[off] ^ 8'($urandom_range(1, 255));
    end
    cut = file_bytes.size();
    if (long_fmt) cut = 20 + n_skip;
    else if ($urandom_range(0, 19) == 0) cut = $urandom_range(1, cut);
    send_queued(cut);
  endtask

  initial begin
    int unsigned base;
    bit          flipped;
    bit          calm;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.byte_value    <= '0;
    in_if.start_of_file <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stray bytes before any start, restart inside the tag, bad riff tag
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h52, 1'b1);
    send_byte(8'h49, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h46, 1'b0);
    send_byte(8'h46, 1'b0);
    send_byte(8'h12, 1'b0);
    // all-ones fields, partial last frame, trailing byte ignored
    build_file(32'd16, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd3,
               16'hFFFF, 32'd7, 7);
    append_byte(8'hA5);
    send_queued(file_bytes.size());

    base    = tracker.live_bytes;
    flipped = 1'b0;
    calm    = 1'b0;
    while (tracker.live_bytes - base < RandomBytes) begin
      if (!flipped && tracker.live_bytes - base >= RandomBytes / 3) begin
        hold_until_drained();
        send_idle_pct = 47;
        recv_idle_pct = 10;
        flipped       = 1'b1;
      end else if (!calm && tracker.live_bytes - base >= 2 * RandomBytes / 3) begin
        hold_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        calm          = 1'b1;
      end
      send_random_file();
    end

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/wavhp_pkg.sv
rtl/wavhp_if.sv
rtl/wavhp_in_stage.sv
rtl/wavhp_parse.sv
rtl/wav_header_parser_core.sv
bench/wav_header_parser_core_tb.sv
